// ----- rtl/bpc_pkg.sv -----
package bpc_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  localparam logic [1:0] REG_CAL_A = 2'd0;
  localparam logic [1:0] REG_CAL_B = 2'd1;
  localparam logic [1:0] REG_CAL_C = 2'd2;

  localparam int TDIV_DW = 27;
  localparam int TDIV_VW = 17;
  localparam int TDIV_SW = 35;

  localparam int PDIV_DW = 32;
  localparam int PDIV_VW = 17;
  localparam int PDIV_SW = 29;

  localparam logic signed [29:0] B6_OFFSET   = 30'sd4000;
  localparam logic [31:0]        B4_OFFSET   = 32'd32768;
  localparam logic [31:0]        B7_SCALE    = 32'd50000;
  localparam logic signed [31:0] P_COEF_SQ   = 32'sd3038;
  localparam logic signed [31:0] P_COEF_LIN  = -32'sd7357;
  localparam logic signed [17:0] P_COEF_OFS  = 18'sd3791;
  localparam logic signed [31:0] P_MAX       = 32'sd1048575;
  localparam logic signed [25:0] T_MAX       = 26'sd32767;
  localparam logic signed [25:0] T_MIN       = -26'sd32768;

endpackage

// ----- rtl/barometric_pressure_compensation_unit.sv -----
// barometric pressure compensation unit
// input channel: raw_temperature and raw_pressure with in_valid / in_stall;
// an item is taken at a rising edge with in_valid high and in_stall low
// output channel: temperature_tenths, pressure_pa and calc_fault with
// out_valid / out_stall; the result item is held until taken
// calibration words are written over the apb port (cal_word_a at 0x00, cal_word_b at
// 0x08, cal_word_c at 0x10); the user must keep no item in flight then (not enforced)
// out_valid rises once the item has passed 72 register stages: the two rows
// of divider cells (27 for the temperature quotient, 32 for pressure) plus 13
// operand and multiply stages around them
// throughput: one item per cycle while not stalled, every stage handing its
// item on; when the receiver stalls with a result waiting, the whole pipeline
// holds and in_stall is raised; it drops as soon as the result is taken
// reset clears all valid bits and the calibration words to zero
module barometric_pressure_compensation_unit
  import bpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        raw_temperature,
  input  logic [15:0]        raw_pressure,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] temperature_tenths,
  output logic [19:0]        pressure_pa,
  output logic               calc_fault
);

  logic [63:0] cal_word_a;
  logic [63:0] cal_word_b;
  logic [31:0] cal_word_c;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_word_a <= '0;
      cal_word_b <= '0;
      cal_word_c <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CAL_A: cal_word_a <= pwdata;
        REG_CAL_B: cal_word_b <= pwdata;
        REG_CAL_C: cal_word_c <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CAL_A: prdata = cal_word_a;
      REG_CAL_B: prdata = cal_word_b;
      REG_CAL_C: prdata = {32'd0, cal_word_c};
      default:   prdata = '0;
    endcase
  end

  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = $signed(cal_word_a[63:48]);
  assign ac2 = $signed(cal_word_a[47:32]);
  assign ac3 = $signed(cal_word_a[31:16]);
  assign ac4 = cal_word_a[15:0];
  assign ac5 = cal_word_b[63:48];
  assign ac6 = cal_word_b[47:32];
  assign b1  = $signed(cal_word_b[31:16]);
  assign b2  = $signed(cal_word_b[15:0]);
  assign mc  = $signed(cal_word_c[31:16]);
  assign md  = $signed(cal_word_c[15:0]);

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 0: input capture
  logic        v0;
  logic [15:0] ut0, up0;

  // stage 1: x1 for temperature
  logic               v1;
  logic signed [16:0] x1_1;
  logic [15:0]        up1;
  logic signed [16:0] tdiff;
  logic signed [33:0] tprod;

  assign tdiff = $signed({1'b0, ut0}) - $signed({1'b0, ac6});
  assign tprod = 34'(tdiff) * 34'($signed({1'b0, ac5}));

  // stage 2: temperature divider operands
  logic               v2;
  logic [TDIV_DW-1:0] nmag2;
  logic [TDIV_VW-1:0] dmag2;
  logic               neg2, dz2;
  logic signed [16:0] x1_2;
  logic [15:0]        up2;
  logic signed [17:0] dsum;
  logic signed [26:0] tnum;
  logic signed [17:0] dneg;
  logic signed [26:0] nneg;

  assign dsum = 18'(x1_1) + 18'(md);
  assign tnum = $signed({mc, 11'd0});
  assign dneg = -dsum;
  assign nneg = -tnum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ut0   <= raw_temperature;
      up0   <= raw_pressure;
      x1_1  <= tprod[31:15];
      up1   <= up0;
      nmag2 <= tnum[26] ? nneg : tnum;
      dmag2 <= dsum[17] ? dneg[16:0] : dsum[16:0];
      neg2  <= tnum[26] ^ dsum[17];
      dz2   <= (dsum == 18'sd0);
      x1_2  <= x1_1;
      up2   <= up1;
    end
  end

  logic               tq_valid;
  logic [TDIV_DW-1:0] tq;
  logic [TDIV_SW-1:0] tq_side;

  bpc_div_chain #(.DW(TDIV_DW), .VW(TDIV_VW), .SW(TDIV_SW)) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v2),
    .dividend (nmag2),
    .divisor  (dmag2),
    .in_side  ({x1_2, neg2, dz2, up2}),
    .out_valid(tq_valid),
    .quotient (tq),
    .out_side (tq_side)
  );

  // stage 3: b5
  logic signed [16:0] tq_x1;
  logic               tq_neg, tq_dz;
  logic signed [27:0] x2t;
  logic signed [28:0] b5_sum;

  assign tq_x1  = $signed(tq_side[34:18]);
  assign tq_neg = tq_side[17];
  assign tq_dz  = tq_side[16];
  assign x2t    = tq_dz ? 28'sd0 :
                  tq_neg ? -$signed({1'b0, tq}) : $signed({1'b0, tq});
  assign b5_sum = 29'(tq_x1) + 29'(x2t);

  logic               v3;
  logic signed [28:0] b5_3;
  logic [15:0]        up3;
  logic               f3;

  // stage 4: t and b6
  logic signed [29:0] t_rnd;
  logic               v4;
  logic signed [25:0] t4;
  logic signed [29:0] b6_4;
  logic [15:0]        up4;
  logic               f4;

  assign t_rnd = 30'(b5_3) + 30'sd8;

  // stage 5: sq and linear terms
  logic signed [31:0] sqp, a2p, a3p;
  logic               v5;
  logic signed [19:0] sq5;
  logic signed [20:0] a2_5;
  logic signed [18:0] a3_5;
  logic signed [25:0] t5;
  logic [15:0]        up5;
  logic               f5;

  assign sqp = 32'(b6_4) * 32'(b6_4);
  assign a2p = 32'(ac2) * 32'(b6_4);
  assign a3p = 32'(ac3) * 32'(b6_4);

  // stage 6: square terms
  logic signed [31:0] b2p, b1p;
  logic               v6;
  logic signed [20:0] xb2_6, a2_6;
  logic signed [15:0] xb1_6;
  logic signed [18:0] a3_6;
  logic signed [25:0] t6;
  logic [15:0]        up6;
  logic               f6;

  assign b2p = 32'(b2) * 32'(sq5);
  assign b1p = 32'(b1) * 32'(sq5);

  // stage 7: b3 and x3
  logic signed [21:0] x3s;
  logic signed [23:0] b3s, b3r;
  logic signed [19:0] x3u;
  logic               v7;
  logic signed [21:0] b3_7;
  logic signed [17:0] x3_7;
  logic signed [25:0] t7;
  logic [15:0]        up7;
  logic               f7;

  assign x3s = 22'(xb2_6) + 22'(a2_6);
  assign b3s = 24'($signed({ac1, 2'b00})) + 24'(x3s) + 24'sd2;
  assign b3r = b3s[23] ? (b3s + 24'sd3) : b3s;
  assign x3u = 20'(a3_6) + 20'(xb1_6) + 20'sd2;

  // stage 8: b4 and b7
  logic [31:0] x3o, b4p, dup, b7p;
  logic        v8;
  logic [16:0] b4_8;
  logic [31:0] b7_8;
  logic signed [25:0] t8;
  logic        f8;

  assign x3o = 32'(x3_7) + B4_OFFSET;
  assign b4p = 32'(ac4) * x3o;
  assign dup = 32'(up7) - 32'(b3_7);
  assign b7p = dup * B7_SCALE;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else if (adv) begin
      v3 <= tq_valid;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b5_3  <= b5_sum;
      up3   <= tq_side[15:0];
      f3    <= tq_dz;
      t4    <= t_rnd[29:4];
      b6_4  <= 30'(b5_3) - B6_OFFSET;
      up4   <= up3;
      f4    <= f3;
      sq5   <= sqp[31:12];
      a2_5  <= a2p[31:11];
      a3_5  <= a3p[31:13];
      t5    <= t4;
      up5   <= up4;
      f5    <= f4;
      xb2_6 <= b2p[31:11];
      xb1_6 <= b1p[31:16];
      a2_6  <= a2_5;
      a3_6  <= a3_5;
      t6    <= t5;
      up6   <= up5;
      f6    <= f5;
      b3_7  <= b3r[23:2];
      x3_7  <= x3u[19:2];
      t7    <= t6;
      up7   <= up6;
      f7    <= f6;
      b4_8  <= b4p[31:15];
      b7_8  <= b7p;
      t8    <= t7;
      f8    <= f7;
    end
  end

  logic               pq_valid;
  logic [PDIV_DW-1:0] pq;
  logic [PDIV_SW-1:0] pq_side;
  logic               ovf8, b4z8;
  logic [31:0]        pdiv_in;

  assign ovf8    = b7_8[31];
  assign b4z8    = (b4_8 == 17'd0);
  assign pdiv_in = ovf8 ? b7_8 : {b7_8[30:0], 1'b0};

  bpc_div_chain #(.DW(PDIV_DW), .VW(PDIV_VW), .SW(PDIV_SW)) u_pdiv (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (v8),
    .dividend (pdiv_in),
    .divisor  (b4_8),
    .in_side  ({t8, f8, ovf8, b4z8}),
    .out_valid(pq_valid),
    .quotient (pq),
    .out_side (pq_side)
  );

  // stage 10: p
  logic        pq_ovf, pq_b4z;
  logic [31:0] pq_fix;

  assign pq_ovf = pq_side[1];
  assign pq_b4z = pq_side[0];
  assign pq_fix = pq_ovf ? {pq[30:0], 1'b0} : pq;

  logic               v10;
  logic signed [31:0] p10;
  logic signed [25:0] t10;
  logic               f10;

  // stage 11
  logic signed [23:0] pa;
  logic signed [31:0] m1p, lp;
  logic               v11;
  logic signed [31:0] m1_11, p11;
  logic signed [15:0] xl_11;
  logic signed [25:0] t11;
  logic               f11;

  assign pa  = p10[31:8];
  assign m1p = 32'(pa) * 32'(pa);
  assign lp  = p10 * P_COEF_LIN;

  // stage 12
  logic signed [31:0] m2p;
  logic               v12;
  logic signed [15:0] xq_12, xl_12;
  logic signed [31:0] p12;
  logic signed [25:0] t12;
  logic               f12;

  assign m2p = m1_11 * P_COEF_SQ;

  // output stage
  logic signed [17:0] corr;
  logic signed [31:0] pr;
  logic               t_hi, t_lo, p_hi, p_lo;

  assign corr = 18'(xq_12) + 18'(xl_12) + P_COEF_OFS;
  assign pr   = p12 + 32'($signed(corr[17:4]));
  assign t_hi = (t12 > T_MAX);
  assign t_lo = (t12 < T_MIN);
  assign p_hi = (pr > P_MAX);
  assign p_lo = pr[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      v10       <= 1'b0;
      v11       <= 1'b0;
      v12       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v10       <= pq_valid;
      v11       <= v10;
      v12       <= v11;
      out_valid <= v12;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p10   <= pq_b4z ? 32'sd0 : $signed(pq_fix);
      t10   <= $signed(pq_side[28:3]);
      f10   <= pq_side[2] | pq_b4z;
      m1_11 <= m1p;
      xl_11 <= lp[31:16];
      p11   <= p10;
      t11   <= t10;
      f11   <= f10;
      xq_12 <= m2p[31:16];
      xl_12 <= xl_11;
      p12   <= p11;
      t12   <= t11;
      f12   <= f11;
      temperature_tenths <= t_hi ? T_MAX[15:0] : t_lo ? T_MIN[15:0] : t12[15:0];
      pressure_pa        <= p_hi ? P_MAX[19:0] : p_lo ? 20'd0 : pr[19:0];
      calc_fault         <= f12 | t_hi | t_lo | p_hi | p_lo;
    end
  end

endmodule

// ----- rtl/bpc_div_cell.sv -----
module bpc_div_cell
  import bpc_pkg::*;
#(
  parameter int DW = 32,
  parameter int VW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [VW-1:0] in_rem,
  input  logic [DW-1:0] in_quo,
  input  logic [VW-1:0] in_dvs,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [VW-1:0] out_rem,
  output logic [DW-1:0] out_quo,
  output logic [VW-1:0] out_dvs,
  output logic [SW-1:0] out_side
);

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          qbit;
  logic [VW-1:0] rem_next;

  assign trial    = {in_rem, in_quo[DW-1]};
  assign diff     = trial - {1'b0, in_dvs};
  assign qbit     = (trial >= {1'b0, in_dvs});
  assign rem_next = qbit ? diff[VW-1:0] : trial[VW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_quo  <= {in_quo[DW-2:0], qbit};
      out_dvs  <= in_dvs;
      out_side <= in_side;
    end
  end

endmodule

// ----- rtl/bpc_div_chain.sv -----
module bpc_div_chain
  import bpc_pkg::*;
#(
  parameter int DW = 32,
  parameter int VW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [DW-1:0] quotient,
  output logic [SW-1:0] out_side
);

  logic          v   [DW+1];
  logic [VW-1:0] rem [DW+1];
  logic [DW-1:0] quo [DW+1];
  logic [VW-1:0] dvs [DW+1];
  logic [SW-1:0] sd  [DW+1];

  assign v[0]   = in_valid;
  assign rem[0] = '0;
  assign quo[0] = dividend;
  assign dvs[0] = divisor;
  assign sd[0]  = in_side;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    bpc_div_cell #(.DW(DW), .VW(VW), .SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v[i]),
      .in_rem   (rem[i]),
      .in_quo   (quo[i]),
      .in_dvs   (dvs[i]),
      .in_side  (sd[i]),
      .out_valid(v[i+1]),
      .out_rem  (rem[i+1]),
      .out_quo  (quo[i+1]),
      .out_dvs  (dvs[i+1]),
      .out_side (sd[i+1])
    );
  end

  assign out_valid = v[DW];
  assign quotient  = quo[DW];
  assign out_side  = sd[DW];

endmodule
